/* rtl/core/psco_pkg.sv */
// ============================================================================
// Plane slice convex outline: shared package
// Types, widths, register indexes and small helper functions that are used
// by the edge front end, the queue, the divider and the outline engine.
// ============================================================================
package psco_pkg;

    // Coordinate and arithmetic widths.
    localparam int COORD_W        = 24;
    localparam int DIFF_W         = 25;
    localparam int PROD_W         = 50;
    localparam int QUO_W          = 25;
    localparam int TOL_W          = 8;
    localparam int CFG_DATA_W     = 24;
    localparam int CFG_IDX_W      = 1;

    // Sizes.
    localparam int MAX_POINTS_DEF = 32;
    localparam int RESULT_LIMIT   = 32;
    localparam int QUEUE_DEPTH    = 4;

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SLICE_HEIGHT = 1'b0;
    localparam t_cfg_idx CFG_POINT_TOL    = 1'b1;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;

    // One input transaction: a 3D edge.
    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord start_z;
        t_coord end_x;
        t_coord end_y;
        t_coord end_z;
        logic   final_edge;
    } t_edge;

    // One output transaction: an outline segment.
    typedef struct packed {
        t_coord seg_start_x;
        t_coord seg_start_y;
        t_coord seg_end_x;
        t_coord seg_end_y;
        logic   has_segment;
        logic   final_segment;
        logic   overflowed;
    } t_seg;

    // A 2D point.
    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_pt;

    // A classified edge waiting in the queue.
    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_diff  dx;
        t_diff  dy;
        t_diff  num;
        t_diff  den;
        logic   hit;
        logic   last;
    } t_job;

    // Divider request and response.
    typedef struct packed {
        logic                     start;
        logic signed [PROD_W-1:0] num;
        t_diff                    den;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_diff quo;
    } t_div_rsp;

    // Sign-extended difference a - b.
    function automatic t_diff sub_ext(t_coord a, t_coord b);
        t_diff d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d;
    endfunction

    // Lexicographic order on (x, y).
    function automatic logic pt_before(t_pt a, t_pt b);
        logic r;
        r = (a.x != b.x) ? (a.x < b.x) : (a.y < b.y);
        return r;
    endfunction

    // True when both axis distances are within the tolerance.
    function automatic logic pt_near(t_pt a, t_pt b, logic [TOL_W-1:0] tol);
        t_diff             dx;
        t_diff             dy;
        logic [DIFF_W-1:0] mx;
        logic [DIFF_W-1:0] my;
        dx = sub_ext(a.x, b.x);
        dy = sub_ext(a.y, b.y);
        mx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        my = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        return (mx <= DIFF_W'(tol)) && (my <= DIFF_W'(tol));
    endfunction

    // Packs one result.
    function automatic t_seg mk_seg(t_pt a, t_pt b, logic has, logic fin, logic ovf);
        t_seg s;
        s.seg_start_x   = a.x;
        s.seg_start_y   = a.y;
        s.seg_end_x     = b.x;
        s.seg_end_y     = b.y;
        s.has_segment   = has;
        s.final_segment = fin;
        s.overflowed    = ovf;
        return s;
    endfunction

endpackage

/* rtl/core/psco_front.sv */
// ============================================================================
// Plane slice convex outline: edge front end
// Accepts edges and classifies them against the slice plane. Each edge is
// reduced to the differences the intersection needs and pushed to the queue.
// ============================================================================
module psco_front import psco_pkg::*; (
    input  logic   i_valid,
    input  t_edge  i_edge,
    output logic   o_stall,
    input  t_coord i_slice,
    input  logic   i_full,
    output logic   o_push,
    output t_job   o_job
);

    t_diff da;
    t_diff db;
    logic  straddle;

    // Accept whenever the queue has room.
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // Classification against the plane: straddling and not flat.
    always_comb begin
        da       = sub_ext(i_edge.start_z, i_slice);
        db       = sub_ext(i_edge.end_z, i_slice);
        straddle = ((da <= 0) && (db >= 0)) || ((da >= 0) && (db <= 0));
        o_job.ax   = i_edge.start_x;
        o_job.ay   = i_edge.start_y;
        o_job.dx   = sub_ext(i_edge.end_x, i_edge.start_x);
        o_job.dy   = sub_ext(i_edge.end_y, i_edge.start_y);
        o_job.num  = sub_ext(i_slice, i_edge.start_z);
        o_job.den  = sub_ext(i_edge.end_z, i_edge.start_z);
        o_job.hit  = straddle && (i_edge.start_z != i_edge.end_z);
        o_job.last = i_edge.final_edge;
    end

endmodule

/* rtl/core/psco_fifo.sv */
// ============================================================================
// Plane slice convex outline: job queue
// A short first-in first-out queue of classified edges between the front
// end and the outline engine.
// ============================================================================
module psco_fifo import psco_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output logic o_full,
    output logic o_not_empty,
    output t_job o_head
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_job          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full      = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_head      = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* rtl/core/psco_div.sv */
// ============================================================================
// Plane slice convex outline: iterative divider
// Signed division truncated toward zero, one quotient bit per cycle. The
// quotient is known to fit QUO_W bits, so the long division starts with
// the upper part of the dividend already in the remainder.
// ============================================================================
module psco_div import psco_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIFF_W:0]   r_rem;
    logic [QUO_W-1:0]  r_low;
    logic [QUO_W-1:0]  r_qmag;
    logic [DIFF_W-1:0] r_dmag;
    logic              r_neg;
    logic              r_done;
    t_diff             r_quo;

    logic [PROD_W-1:0] nmag;
    logic [DIFF_W-1:0] dmag;
    logic [DIFF_W:0]   trial;
    logic              ge;

    // Operand magnitudes and one restoring step.
    always_comb begin
        nmag  = i_req.num[PROD_W-1] ? PROD_W'(-i_req.num) : PROD_W'(i_req.num);
        dmag  = i_req.den[DIFF_W-1] ? DIFF_W'(-i_req.den) : DIFF_W'(i_req.den);
        trial = {r_rem[DIFF_W-1:0], r_low[QUO_W-1]};
        ge    = (trial >= {1'b0, r_dmag});
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    // Iteration control and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W);
                r_rem  <= {1'b0, nmag[PROD_W-1:QUO_W]};
                r_low  <= nmag[QUO_W-1:0];
                r_dmag <= dmag;
                r_qmag <= '0;
                r_neg  <= i_req.num[PROD_W-1] ^ i_req.den[DIFF_W-1];
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_rem  <= ge ? (trial - {1'b0, r_dmag}) : trial;
                    r_low  <= {r_low[QUO_W-2:0], 1'b0};
                    r_qmag <= {r_qmag[QUO_W-2:0], ge};
                    r_cnt  <= r_cnt - CNT_W'(1);
                end else begin
                    r_quo  <= r_neg ? -t_diff'(r_qmag) : t_diff'(r_qmag);
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

/* rtl/core/psco_back.sv */
// ============================================================================
// Plane slice convex outline: outline engine
// Computes intersection points with a shared multiplier and the divider,
// stores them, and on the last edge removes near duplicates, sorts the
// points, builds the monotone-chain hull and emits the closed loop.
// ============================================================================
module psco_back import psco_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    input  t_job             i_job,
    output logic             o_job_pop,
    input  logic [TOL_W-1:0] i_tol,
    output t_div_req         o_div_req,
    input  t_div_rsp         i_div_rsp,
    output logic             o_valid,
    input  logic             i_stall,
    output t_seg             o_seg
);

    localparam int PA    = $clog2(MAX_POINTS);
    localparam int PW    = $clog2(MAX_POINTS + 1);
    localparam int HA    = $clog2(2 * MAX_POINTS);
    localparam int HW    = $clog2(2 * MAX_POINTS + 1);
    localparam int LIM_W = $clog2(RESULT_LIMIT + 1);

    typedef enum logic [5:0] {
        S_IDLE, S_MULX, S_DIVX_GO, S_DIVX_W, S_MULY, S_DIVY_GO, S_DIVY_W, S_STORE,
        S_FIN, S_DD_RDP, S_DD_LDP, S_DD_RDU, S_DD_CMP, S_DD_ADD, S_DD_NEXT, S_DD_DONE,
        S_CP_RD, S_CP_WR, S_SO_RDK, S_SO_LDK, S_SO_RDJ, S_SO_CMP, S_SO_PUT,
        S_HU_RD, S_HU_LD, S_HU_CHK, S_CR1, S_CR2, S_CR3, S_POP_LD, S_HU_PUSH,
        S_HU_END, S_EM_START, S_EM_H0, S_EM_RD, S_EM_CMP, S_EM_LAST
    } t_state;

    // Memories and their registered read data.
    t_pt r_pmem [MAX_POINTS];
    t_pt r_umem [MAX_POINTS];
    t_pt r_hmem [2 * MAX_POINTS];
    t_pt r_pq;
    t_pt r_uq;
    t_pt r_hq;

    // Control and datapath registers.
    t_state                   r_state;
    t_job                     r_job;
    t_coord                   r_px;
    t_coord                   r_py;
    logic [PW-1:0]            r_count;
    logic                     r_ovf;
    logic [HW-1:0]            r_i;
    logic [PW-1:0]            r_j;
    logic [PW-1:0]            r_n;
    logic [PW-1:0]            r_pos;
    logic [PW-1:0]            r_k;
    logic [PW-1:0]            r_sm;
    logic [HW-1:0]            r_base;
    logic [HW-1:0]            r_m;
    logic                     r_half;
    t_pt                      r_cand;
    t_pt                      r_key;
    t_pt                      r_p;
    t_pt                      r_t1;
    t_pt                      r_t2;
    t_pt                      r_h0;
    t_pt                      r_prev;
    t_pt                      r_pend_a;
    t_pt                      r_pend_b;
    logic                     r_pend_v;
    logic [LIM_W-1:0]         r_found;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_prod2;
    logic                     r_out_valid;
    t_seg                     r_out;

    // Combinational helpers.
    t_diff         mul_a;
    t_diff         mul_b;
    logic [PA-1:0] u_raddr;
    logic [HA-1:0] h_raddr;
    logic          p_we;
    logic          u_we;
    logic [PA-1:0] u_waddr;
    t_pt           u_wdata;
    logic          h_we;
    logic [HA-1:0] h_waddr;
    t_pt           h_wdata;
    logic [PW-1:0] hu_idx;
    logic [HW-1:0] h_top;
    logic [HW-1:0] h_back3;
    logic [HW-1:0] i_inc;
    logic [PW-1:0] j_inc;
    logic [PW-1:0] k_inc;
    logic [LIM_W-1:0] found_inc;
    t_diff         coord_sum;
    t_pt           cur;
    logic          seg_new;
    logic          out_free;

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_valid   = r_out_valid;
    assign o_seg     = r_out;
    assign out_free  = !r_out_valid || !i_stall;

    assign o_div_req.start = (r_state == S_DIVX_GO) || (r_state == S_DIVY_GO);
    assign o_div_req.num   = r_prod;
    assign o_div_req.den   = r_job.den;

    // Counters, addresses and the emission compare.
    always_comb begin
        i_inc     = r_i + HW'(1);
        j_inc     = r_j + PW'(1);
        k_inc     = r_k + PW'(1);
        found_inc = r_found + LIM_W'(1);
        hu_idx    = r_half ? (r_n - PW'(1) - r_k) : r_k;
        h_top     = r_base + HW'(r_sm);
        h_back3   = h_top - HW'(3);
        coord_sum = (r_state == S_DIVY_W) ? {r_job.ay[COORD_W-1], r_job.ay}
                                          : {r_job.ax[COORD_W-1], r_job.ax};
        coord_sum = coord_sum + i_div_rsp.quo;
        cur       = (r_i == r_m) ? r_h0 : r_hq;
        seg_new   = (cur != r_prev);
    end

    // Multiplier operands, memory addresses and write strobes.
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        u_raddr = '0;
        h_raddr = r_i[HA-1:0];
        p_we    = 1'b0;
        u_we    = 1'b0;
        u_waddr = '0;
        u_wdata = r_key;
        h_we    = 1'b0;
        h_waddr = h_top[HA-1:0];
        h_wdata = r_p;
        case (r_state)
            S_MULX: begin
                mul_a = r_job.dx;
                mul_b = r_job.num;
            end
            S_MULY: begin
                mul_a = r_job.dy;
                mul_b = r_job.num;
            end
            S_CR1: begin
                mul_a = sub_ext(r_t1.x, r_t2.x);
                mul_b = sub_ext(r_p.y, r_t2.y);
            end
            S_CR2: begin
                mul_a = sub_ext(r_t1.y, r_t2.y);
                mul_b = sub_ext(r_p.x, r_t2.x);
            end
            S_CR3: begin
                h_raddr = h_back3[HA-1:0];
            end
            S_STORE: begin
                p_we = (r_count < PW'(MAX_POINTS));
            end
            S_DD_RDU, S_SO_RDJ: begin
                u_raddr = r_j[PA-1:0];
            end
            S_DD_ADD: begin
                u_we    = 1'b1;
                u_waddr = r_n[PA-1:0];
                u_wdata = r_cand;
            end
            S_CP_RD, S_SO_RDK: begin
                u_raddr = r_i[PA-1:0];
            end
            S_CP_WR: begin
                h_we    = 1'b1;
                h_waddr = r_i[HA-1:0];
                h_wdata = r_uq;
            end
            S_SO_CMP: begin
                u_we    = pt_before(r_key, r_uq);
                u_waddr = j_inc[PA-1:0];
                u_wdata = r_uq;
            end
            S_SO_PUT: begin
                u_we    = 1'b1;
                u_waddr = r_pos[PA-1:0];
            end
            S_HU_RD: begin
                u_raddr = hu_idx[PA-1:0];
            end
            S_HU_PUSH: begin
                h_we = 1'b1;
            end
            S_EM_START: begin
                h_raddr = '0;
            end
            default: begin
            end
        endcase
    end

    // Memory ports, all reads registered.
    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pmem[r_count[PA-1:0]] <= '{x: r_px, y: r_py};
        end
        if (u_we) begin
            r_umem[u_waddr] <= u_wdata;
        end
        if (h_we) begin
            r_hmem[h_waddr] <= h_wdata;
        end
        r_pq <= r_pmem[r_i[PA-1:0]];
        r_uq <= r_umem[u_raddr];
        r_hq <= r_hmem[h_raddr];
    end

    // Sequencer with its registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend_v    <= 1'b0;
        end else begin
            r_prod <= mul_a * mul_b;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                // Take the next edge from the queue.
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job <= i_job;
                        if (i_job.hit) begin
                            r_state <= S_MULX;
                        end else if (i_job.last) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                // Intersection point: product, then division, per axis.
                S_MULX:    r_state <= S_DIVX_GO;
                S_DIVX_GO: r_state <= S_DIVX_W;
                S_DIVX_W: begin
                    if (i_div_rsp.done) begin
                        r_px    <= coord_sum[COORD_W-1:0];
                        r_state <= S_MULY;
                    end
                end
                S_MULY:    r_state <= S_DIVY_GO;
                S_DIVY_GO: r_state <= S_DIVY_W;
                S_DIVY_W: begin
                    if (i_div_rsp.done) begin
                        r_py    <= coord_sum[COORD_W-1:0];
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    if (r_count < PW'(MAX_POINTS)) begin
                        r_count <= r_count + PW'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                    r_state <= r_job.last ? S_FIN : S_IDLE;
                end
                // Last edge: too few raw points gives an empty outline.
                S_FIN: begin
                    r_i <= '0;
                    r_n <= '0;
                    if (r_count < PW'(3)) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_EM_LAST;
                    end else begin
                        r_state <= S_DD_RDP;
                    end
                end
                // Near-duplicate removal against the unique list so far.
                S_DD_RDP: r_state <= S_DD_LDP;
                S_DD_LDP: begin
                    r_cand  <= r_pq;
                    r_j     <= '0;
                    r_state <= (r_n == '0) ? S_DD_ADD : S_DD_RDU;
                end
                S_DD_RDU: r_state <= S_DD_CMP;
                S_DD_CMP: begin
                    if (pt_near(r_uq, r_cand, i_tol)) begin
                        r_state <= S_DD_NEXT;
                    end else if (j_inc == r_n) begin
                        r_state <= S_DD_ADD;
                    end else begin
                        r_j     <= j_inc;
                        r_state <= S_DD_RDU;
                    end
                end
                S_DD_ADD: begin
                    r_n     <= r_n + PW'(1);
                    r_state <= S_DD_NEXT;
                end
                S_DD_NEXT: begin
                    if (i_inc == HW'(r_count)) begin
                        r_state <= S_DD_DONE;
                    end else begin
                        r_i     <= i_inc;
                        r_state <= S_DD_RDP;
                    end
                end
                S_DD_DONE: begin
                    if (r_n < PW'(3)) begin
                        r_i     <= '0;
                        r_state <= S_CP_RD;
                    end else begin
                        r_i     <= HW'(1);
                        r_state <= S_SO_RDK;
                    end
                end
                // Fewer than three unique points form the loop unsorted.
                S_CP_RD: r_state <= S_CP_WR;
                S_CP_WR: begin
                    if (i_inc == HW'(r_n)) begin
                        r_m     <= HW'(r_n);
                        r_state <= S_EM_START;
                    end else begin
                        r_i     <= i_inc;
                        r_state <= S_CP_RD;
                    end
                end
                // Insertion sort by x, then y.
                S_SO_RDK: r_state <= S_SO_LDK;
                S_SO_LDK: begin
                    r_key   <= r_uq;
                    r_j     <= r_i[PW-1:0] - PW'(1);
                    r_state <= S_SO_RDJ;
                end
                S_SO_RDJ: r_state <= S_SO_CMP;
                S_SO_CMP: begin
                    if (pt_before(r_key, r_uq)) begin
                        if (r_j == '0) begin
                            r_pos   <= '0;
                            r_state <= S_SO_PUT;
                        end else begin
                            r_j     <= r_j - PW'(1);
                            r_state <= S_SO_RDJ;
                        end
                    end else begin
                        r_pos   <= j_inc;
                        r_state <= S_SO_PUT;
                    end
                end
                S_SO_PUT: begin
                    if (i_inc == HW'(r_n)) begin
                        r_half  <= 1'b0;
                        r_base  <= '0;
                        r_sm    <= '0;
                        r_k     <= '0;
                        r_state <= S_HU_RD;
                    end else begin
                        r_i     <= i_inc;
                        r_state <= S_SO_RDK;
                    end
                end
                // Monotone chain: the two stack tops are cached in registers.
                S_HU_RD: r_state <= S_HU_LD;
                S_HU_LD: begin
                    r_p     <= r_uq;
                    r_state <= S_HU_CHK;
                end
                S_HU_CHK: r_state <= (r_sm >= PW'(2)) ? S_CR1 : S_HU_PUSH;
                S_CR1:    r_state <= S_CR2;
                S_CR2: begin
                    r_prod2 <= r_prod;
                    r_state <= S_CR3;
                end
                // Cross product not positive: pop and reload the new second top.
                S_CR3: begin
                    if (r_prod2 <= r_prod) begin
                        r_sm    <= r_sm - PW'(1);
                        r_t1    <= r_t2;
                        r_state <= (r_sm >= PW'(3)) ? S_POP_LD : S_HU_CHK;
                    end else begin
                        r_state <= S_HU_PUSH;
                    end
                end
                S_POP_LD: begin
                    r_t2    <= r_hq;
                    r_state <= S_HU_CHK;
                end
                S_HU_PUSH: begin
                    r_t2 <= r_t1;
                    r_t1 <= r_p;
                    r_sm <= r_sm + PW'(1);
                    if (k_inc == r_n) begin
                        r_state <= S_HU_END;
                    end else begin
                        r_k     <= k_inc;
                        r_state <= S_HU_RD;
                    end
                end
                // The upper half starts on the last point of the lower half.
                S_HU_END: begin
                    if (!r_half) begin
                        r_base  <= h_top - HW'(1);
                        r_half  <= 1'b1;
                        r_sm    <= '0;
                        r_k     <= '0;
                        r_state <= S_HU_RD;
                    end else begin
                        r_m     <= h_top - HW'(1);
                        r_state <= S_EM_START;
                    end
                end
                // Emission walks the loop and holds one segment back.
                S_EM_START: r_state <= S_EM_H0;
                S_EM_H0: begin
                    r_h0     <= r_hq;
                    r_prev   <= r_hq;
                    r_i      <= HW'(1);
                    r_found  <= '0;
                    r_pend_v <= 1'b0;
                    r_state  <= S_EM_RD;
                end
                S_EM_RD: r_state <= S_EM_CMP;
                S_EM_CMP: begin
                    if (!(seg_new && r_pend_v && !out_free)) begin
                        if (seg_new) begin
                            if (r_pend_v) begin
                                r_out       <= mk_seg(r_pend_a, r_pend_b, 1'b1, 1'b0, r_ovf);
                                r_out_valid <= 1'b1;
                            end
                            r_pend_a <= r_prev;
                            r_pend_b <= cur;
                            r_pend_v <= 1'b1;
                            r_found  <= found_inc;
                        end
                        r_prev <= cur;
                        if ((seg_new && (found_inc == LIM_W'(RESULT_LIMIT))) ||
                            (r_i == r_m)) begin
                            r_state <= S_EM_LAST;
                        end else begin
                            r_i     <= i_inc;
                            r_state <= S_EM_RD;
                        end
                    end
                end
                // Final result, or the empty outline, then clear the shape.
                S_EM_LAST: begin
                    if (out_free) begin
                        if (r_pend_v) begin
                            r_out <= mk_seg(r_pend_a, r_pend_b, 1'b1, 1'b1, r_ovf);
                        end else begin
                            r_out <= mk_seg('0, '0, 1'b0, 1'b1, r_ovf);
                        end
                        r_out_valid <= 1'b1;
                        r_pend_v    <= 1'b0;
                        r_count     <= '0;
                        r_ovf       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/core/plane_slice_convex_outline.sv */
// ============================================================================
// Plane slice convex outline: top level
// Slices a stream of 3D edges at a programmable height and emits the convex
// outline of the cut as a closed loop of 2D segments.
// ============================================================================
//
//  Channel   Signals                              Moves
//  -------   ----------------------------------   ---------------------------
//  edge in   i_valid, o_stall, i_edge             one 3D edge per transaction
//  segment   o_valid, i_stall, o_seg              one segment per transaction
//  config    i_cfg_we, i_cfg_index, i_cfg_data    one register write per cycle
//
//  An edge that misses the plane is consumed in the idle state; an edge that
//  hits it waits on the shared divider, at one quotient bit per cycle, twice
//  per point. The last edge adds the outline pass, which grows with the
//  square of the point count (duplicate search, sort).
//  Reset is synchronous and active low; there is no clearing pass.
//  A four-entry queue lets edges arrive while the engine works or the
//  segment output is stalled.
// ============================================================================
module plane_slice_convex_outline import psco_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_edge                 i_edge,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_seg                  o_seg,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_coord           r_slice;
    logic [TOL_W-1:0] r_tol;

    logic     push;
    t_job     push_job;
    logic     full;
    logic     not_empty;
    logic     pop;
    t_job     head;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice <= '0;
            r_tol   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SLICE_HEIGHT: r_slice <= t_coord'(i_cfg_data);
                CFG_POINT_TOL:    r_tol   <= i_cfg_data[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    psco_front u_front (
        .i_valid (i_valid),
        .i_edge  (i_edge),
        .o_stall (o_stall),
        .i_slice (r_slice),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    psco_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (push_job),
        .i_pop       (pop),
        .o_full      (full),
        .o_not_empty (not_empty),
        .o_head      (head)
    );

    psco_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    psco_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (not_empty),
        .i_job       (head),
        .o_job_pop   (pop),
        .i_tol       (r_tol),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_seg       (o_seg)
    );

endmodule

/* rtl/core/psco_checker.sv */
// ============================================================================
// Plane slice convex outline: port checker
// Concurrent checks on what the top-level ports show over time, attached
// to the top level by a bind statement.
// ============================================================================
module psco_checker import psco_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input t_edge                 i_edge,
    input logic                  o_valid,
    input logic                  i_stall,
    input t_seg                  o_seg
);

    // A stalled edge transaction stays offered and unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_edge))
        else $error("stalled edge changed");

    // A stalled segment transaction stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_seg))
        else $error("stalled segment changed");

    // An empty outline is always the last result of its shape.
    a_empty_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_seg.has_segment |-> o_seg.final_segment)
        else $error("empty outline not marked final");

    // An empty outline carries zero coordinates.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_seg.has_segment |->
            (o_seg.seg_start_x == '0) && (o_seg.seg_start_y == '0) &&
            (o_seg.seg_end_x == '0) && (o_seg.seg_end_y == '0))
        else $error("empty outline has coordinates");

    // Reset leaves no segment pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("segment valid after reset");

endmodule

bind plane_slice_convex_outline psco_checker u_psco_checker (.*);
